// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at each rising clock edge, skipped while reset is high.
`define ASSERT_SYNC(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// Check a property at each rising clock edge, reset cycles included.
`define ASSERT_SYNC_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) (prop)) \
      else $error("assertion failed");

`endif

// ===== rtl/ssdbd_pkg.sv =====
// Shared constants, payload types and register indexes of the SSD box decoder.
// Depends on nothing; every other RTL file but assert_macros.svh imports it.
`default_nettype none
package ssdbd_pkg;

   localparam int COORD_BITS = 13;
   localparam int FRAC_BITS  = 14;
   localparam int REL_BITS   = 16;
   localparam int SCORE_BITS = 17;
   localparam int PROD_BITS  = REL_BITS + COORD_BITS + 1;
   localparam int QUO_BITS   = PROD_BITS - FRAC_BITS;
   localparam int PIX_BITS   = QUO_BITS + 2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = SCORE_BITS;

   localparam int REQ_DATA_BITS = 88;
   localparam int RSP_DATA_BITS = 56;

   localparam logic [CSR_ADDR_BITS-1:0] REG_ROI_LEFT     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROI_TOP      = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROI_SPAN_X   = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] REG_ROI_SPAN_Y   = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAME_SPAN_X = 3'd4;
   localparam logic [CSR_ADDR_BITS-1:0] REG_FRAME_SPAN_Y = 3'd5;
   localparam logic [CSR_ADDR_BITS-1:0] REG_SCORE_THR    = 3'd6;

   typedef struct packed {
      logic [COORD_BITS-1:0] roi_left;
      logic [COORD_BITS-1:0] roi_top;
      logic [COORD_BITS-1:0] roi_span_x;
      logic [COORD_BITS-1:0] roi_span_y;
      logic [COORD_BITS-1:0] frame_span_x;
      logic [COORD_BITS-1:0] frame_span_y;
      logic [SCORE_BITS-1:0] score_threshold;
   } cfg_type;

   typedef struct packed {
      logic signed [REL_BITS-1:0] left;
      logic signed [REL_BITS-1:0] top;
      logic signed [REL_BITS-1:0] right;
      logic signed [REL_BITS-1:0] bottom;
   } rel_set_type;

   typedef struct packed {
      logic signed [PROD_BITS-1:0] left;
      logic signed [PROD_BITS-1:0] top;
      logic signed [PROD_BITS-1:0] right;
      logic signed [PROD_BITS-1:0] bottom;
   } prod_set_type;

   typedef struct packed {
      logic signed [PIX_BITS-1:0] left;
      logic signed [PIX_BITS-1:0] top;
      logic signed [PIX_BITS-1:0] right;
      logic signed [PIX_BITS-1:0] bottom;
   } pix_set_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] box_h;
      logic [COORD_BITS-1:0] box_w;
      logic [COORD_BITS-1:0] box_y;
      logic [COORD_BITS-1:0] box_x;
   } box_type;

endpackage
`default_nettype wire

// ===== rtl/ssd_detection_box_decoder.sv =====
// SSD detection box decoder. Each request transaction carries one detection
// proposal; a proposal that survives the list-stop and score checks yields one
// response transaction with the box scaled by the ROI size, offset by the ROI
// origin and clipped to the frame (an all-zero box when it misses the frame).
// An end-of-list proposal (req_tlast) gives no response and drops all later
// proposals until one flagged with req_tuser (first of a new set) arrives.
// Throughput is one proposal per clock while rsp_tready does not hold the
// pipeline back. A kept proposal passes through the four register stages in
// order: input, product, placed corners, result. Every stage holds while the
// one after it is full and stalled, so back-pressure on rsp_tready reaches
// req_tready only when all four stages are occupied. Write the csr_ registers
// only while no response is outstanding.
// Depends on ssdbd_pkg, ssdbd_admit, ssdbd_scale, ssdbd_clip.
`default_nettype none
module ssd_detection_box_decoder (
   input  wire                                clock,
   input  wire                                reset,
   // Request stream
   input  wire                                req_tvalid,
   output logic                               req_tready,
   // [16:0] score, [32:17] rel_left, [48:33] rel_top, [64:49] rel_right,
   // [80:65] rel_bottom, [87:81] zero
   input  wire [ssdbd_pkg::REQ_DATA_BITS-1:0] req_tdata,
   input  wire                                req_tlast,   // list_end
   input  wire                                req_tuser,   // set_start
   // Response stream
   output logic                               rsp_tvalid,
   input  wire                                rsp_tready,
   // [12:0] box_x, [25:13] box_y, [38:26] box_w, [51:39] box_h, [55:52] zero
   output logic [ssdbd_pkg::RSP_DATA_BITS-1:0] rsp_tdata,
   // Configuration write port
   input  wire                                csr_we,
   input  wire [ssdbd_pkg::CSR_ADDR_BITS-1:0] csr_addr,
   input  wire [ssdbd_pkg::CSR_DATA_BITS-1:0] csr_wdata
);
   import ssdbd_pkg::*;

   cfg_type     cfg_ff, cfg_in;
   rel_set_type req_rel;
   rel_set_type adm_rel;
   pix_set_type scl_pix;
   box_type     rsp_box;
   logic        adm_valid, scl_ready;
   logic        scl_valid, clp_ready;
   logic [SCORE_BITS-1:0] req_score;

   // Unpack the request payload
   assign req_score      = req_tdata[SCORE_BITS-1:0];
   assign req_rel.left   = req_tdata[SCORE_BITS +     REL_BITS - 1 -: REL_BITS];
   assign req_rel.top    = req_tdata[SCORE_BITS + 2 * REL_BITS - 1 -: REL_BITS];
   assign req_rel.right  = req_tdata[SCORE_BITS + 3 * REL_BITS - 1 -: REL_BITS];
   assign req_rel.bottom = req_tdata[SCORE_BITS + 4 * REL_BITS - 1 -: REL_BITS];

   // Configuration registers: take a write on any cycle with csr_we high,
   // drop writes to unknown indexes.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_addr)
            REG_ROI_LEFT:     cfg_in.roi_left        = csr_wdata[COORD_BITS-1:0];
            REG_ROI_TOP:      cfg_in.roi_top         = csr_wdata[COORD_BITS-1:0];
            REG_ROI_SPAN_X:   cfg_in.roi_span_x      = csr_wdata[COORD_BITS-1:0];
            REG_ROI_SPAN_Y:   cfg_in.roi_span_y      = csr_wdata[COORD_BITS-1:0];
            REG_FRAME_SPAN_X: cfg_in.frame_span_x    = csr_wdata[COORD_BITS-1:0];
            REG_FRAME_SPAN_Y: cfg_in.frame_span_y    = csr_wdata[COORD_BITS-1:0];
            REG_SCORE_THR:    cfg_in.score_threshold = csr_wdata[SCORE_BITS-1:0];
            default:          cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.roi_left        <= '0;
         cfg_ff.roi_top         <= '0;
         cfg_ff.roi_span_x      <= COORD_BITS'(1);
         cfg_ff.roi_span_y      <= COORD_BITS'(1);
         cfg_ff.frame_span_x    <= COORD_BITS'(1);
         cfg_ff.frame_span_y    <= COORD_BITS'(1);
         cfg_ff.score_threshold <= SCORE_BITS'(32768);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   // Filter proposals and register the kept ones
   ssdbd_admit u_admit (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (req_tvalid),
      .in_ready  (req_tready),
      .set_start (req_tuser),
      .list_end  (req_tlast),
      .score     (req_score),
      .rel_in    (req_rel),
      .out_valid (adm_valid),
      .out_ready (scl_ready),
      .rel_out   (adm_rel)
   );

   // Scale to pixels and offset by the ROI origin
   ssdbd_scale u_scale (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (adm_valid),
      .in_ready  (scl_ready),
      .rel_in    (adm_rel),
      .out_valid (scl_valid),
      .out_ready (clp_ready),
      .pix_out   (scl_pix)
   );

   // Clip to the frame and hold the result
   ssdbd_clip u_clip (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .in_valid  (scl_valid),
      .in_ready  (clp_ready),
      .pix_in    (scl_pix),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .box_out   (rsp_box)
   );

   assign rsp_tdata = RSP_DATA_BITS'(rsp_box);
endmodule
`default_nettype wire

// ===== rtl/ssdbd_admit.sv =====
// Admission stage: list stop flag, score threshold test and input register.
// Depends on ssdbd_pkg.
`default_nettype none
module ssdbd_admit (
   input  wire                             clock,
   input  wire                             reset,
   input  wire ssdbd_pkg::cfg_type         cfg,
   input  wire                             in_valid,
   output logic                            in_ready,
   input  wire                             set_start,
   input  wire                             list_end,
   input  wire [ssdbd_pkg::SCORE_BITS-1:0] score,
   input  wire ssdbd_pkg::rel_set_type     rel_in,
   output logic                            out_valid,
   input  wire                             out_ready,
   output ssdbd_pkg::rel_set_type          rel_out
);
   import ssdbd_pkg::*;

   logic        valid_ff, valid_in;
   logic        stopped_ff, stopped_in;
   rel_set_type rel_ff;
   logic        accept, stop_eff, keep;

   assign in_ready  = !valid_ff || out_ready;
   assign accept    = in_valid && in_ready;
   assign stop_eff  = stopped_ff && !set_start;
   assign keep      = !stop_eff && !list_end && (score >= cfg.score_threshold);

   always_comb begin
      stopped_in = accept ? (stop_eff || list_end) : stopped_ff;
      valid_in   = in_ready ? (in_valid && keep) : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= 1'b0;
         stopped_ff <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         stopped_ff <= stopped_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rel_ff <= rel_in;
      end
   end

   assign out_valid = valid_ff;
   assign rel_out   = rel_ff;
endmodule
`default_nettype wire

// ===== rtl/ssdbd_scale.sv =====
// Scaling stages: corner times ROI span, then truncate toward zero and add ROI origin.
// Depends on ssdbd_pkg.
`default_nettype none
module ssdbd_scale (
   input  wire                         clock,
   input  wire                         reset,
   input  wire ssdbd_pkg::cfg_type     cfg,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire ssdbd_pkg::rel_set_type rel_in,
   output logic                        out_valid,
   input  wire                         out_ready,
   output ssdbd_pkg::pix_set_type      pix_out
);
   import ssdbd_pkg::*;

   localparam logic signed [PROD_BITS-1:0] ROUND_BIAS =
      PROD_BITS'((1 << FRAC_BITS) - 1);

   logic         prod_valid_ff, prod_valid_in, prod_ready;
   logic         pix_valid_ff, pix_valid_in;
   prod_set_type prod_ff, prod_in;
   pix_set_type  pix_ff, pix_in;
   logic signed [PROD_BITS-1:0] span_x, span_y;
   logic signed [PIX_BITS-1:0]  org_x, org_y;

   function automatic logic signed [PROD_BITS-1:0] mul_corner(
      input logic signed [REL_BITS-1:0]  rel,
      input logic signed [PROD_BITS-1:0] span
   );
      logic signed [PROD_BITS-1:0] rel_ext;
      rel_ext    = PROD_BITS'(rel);
      mul_corner = rel_ext * span;
   endfunction

   // Divide by 2^FRAC_BITS toward zero, then move into frame coordinates.
   function automatic logic signed [PIX_BITS-1:0] place_corner(
      input logic signed [PROD_BITS-1:0] prod,
      input logic signed [PIX_BITS-1:0]  origin
   );
      logic signed [PROD_BITS-1:0] biased;
      logic signed [QUO_BITS-1:0]  quo;
      biased       = prod + (prod[PROD_BITS-1] ? ROUND_BIAS : '0);
      quo          = biased[PROD_BITS-1:FRAC_BITS];
      place_corner = PIX_BITS'(quo) + origin;
   endfunction

   assign span_x = signed'(PROD_BITS'({1'b0, cfg.roi_span_x}));
   assign span_y = signed'(PROD_BITS'({1'b0, cfg.roi_span_y}));
   assign org_x  = signed'(PIX_BITS'({1'b0, cfg.roi_left}));
   assign org_y  = signed'(PIX_BITS'({1'b0, cfg.roi_top}));

   // Multiply stage
   assign prod_ready = !pix_valid_ff || out_ready;
   assign in_ready   = !prod_valid_ff || prod_ready;

   always_comb begin
      prod_in.left   = mul_corner(rel_in.left,   span_x);
      prod_in.top    = mul_corner(rel_in.top,    span_y);
      prod_in.right  = mul_corner(rel_in.right,  span_x);
      prod_in.bottom = mul_corner(rel_in.bottom, span_y);
      prod_valid_in  = in_ready ? in_valid : prod_valid_ff;
   end

   // Placement stage
   always_comb begin
      pix_in.left   = place_corner(prod_ff.left,   org_x);
      pix_in.top    = place_corner(prod_ff.top,    org_y);
      pix_in.right  = place_corner(prod_ff.right,  org_x);
      pix_in.bottom = place_corner(prod_ff.bottom, org_y);
      pix_valid_in  = prod_ready ? prod_valid_ff : pix_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prod_valid_ff <= 1'b0;
         pix_valid_ff  <= 1'b0;
      end else begin
         prod_valid_ff <= prod_valid_in;
         pix_valid_ff  <= pix_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         prod_ff <= prod_in;
      end
      if (prod_valid_ff && prod_ready) begin
         pix_ff <= pix_in;
      end
   end

   assign out_valid = pix_valid_ff;
   assign pix_out   = pix_ff;
endmodule
`default_nettype wire

// ===== rtl/ssdbd_clip.sv =====
// Clip stage: intersect the box with the frame and hold it in the result register.
// Depends on ssdbd_pkg.
`default_nettype none
module ssdbd_clip (
   input  wire                         clock,
   input  wire                         reset,
   input  wire ssdbd_pkg::cfg_type     cfg,
   input  wire                         in_valid,
   output logic                        in_ready,
   input  wire ssdbd_pkg::pix_set_type pix_in,
   output logic                        out_valid,
   input  wire                         out_ready,
   output ssdbd_pkg::box_type          box_out
);
   import ssdbd_pkg::*;

   logic    valid_ff, valid_in;
   box_type box_ff, box_in;
   logic signed [PIX_BITS-1:0] frame_x, frame_y;
   logic signed [PIX_BITS-1:0] x1, y1, x2, y2;
   logic                       empty;

   assign frame_x = signed'(PIX_BITS'({1'b0, cfg.frame_span_x}));
   assign frame_y = signed'(PIX_BITS'({1'b0, cfg.frame_span_y}));
   assign in_ready = !valid_ff || out_ready;

   always_comb begin
      x1 = (pix_in.left < 0) ? '0 : pix_in.left;
      y1 = (pix_in.top  < 0) ? '0 : pix_in.top;
      x2 = (pix_in.right  > frame_x) ? frame_x : pix_in.right;
      y2 = (pix_in.bottom > frame_y) ? frame_y : pix_in.bottom;
      empty = (pix_in.right <= pix_in.left) || (pix_in.bottom <= pix_in.top) ||
              (x2 <= x1) || (y2 <= y1);
      if (empty) begin
         box_in = '0;
      end else begin
         box_in.box_x = x1[COORD_BITS-1:0];
         box_in.box_y = y1[COORD_BITS-1:0];
         box_in.box_w = COORD_BITS'(x2 - x1);
         box_in.box_h = COORD_BITS'(y2 - y1);
      end
      valid_in = in_ready ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_valid && in_ready) begin
         box_ff <= box_in;
      end
   end

   assign out_valid = valid_ff;
   assign box_out   = box_ff;
endmodule
`default_nettype wire

// ===== rtl/ssdbd_checker.sv =====
// Port-level checker for the SSD box decoder, bound to the top level.
// Depends on ssdbd_pkg and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ssdbd_checker (
   input wire                                clock,
   input wire                                reset,
   input wire                                rsp_tvalid,
   input wire                                rsp_tready,
   input wire [ssdbd_pkg::RSP_DATA_BITS-1:0] rsp_tdata
);
   import ssdbd_pkg::*;

   logic [COORD_BITS-1:0] box_x, box_y, box_w, box_h;
   logic                  box_ok;

   assign box_x = rsp_tdata[COORD_BITS-1:0];
   assign box_y = rsp_tdata[2 * COORD_BITS - 1 -: COORD_BITS];
   assign box_w = rsp_tdata[3 * COORD_BITS - 1 -: COORD_BITS];
   assign box_h = rsp_tdata[4 * COORD_BITS - 1 -: COORD_BITS];

   // A box is either empty in both sizes with a zero corner, or non-empty in both
   assign box_ok = ((box_w == '0) == (box_h == '0)) &&
                   ((box_w != '0) || (box_x == '0 && box_y == '0));

   // Reset empties the whole pipeline
   `ASSERT_SYNC_ALWAYS(a_reset_clears, clock, reset |=> !rsp_tvalid)
   // A stalled response stays up and keeps its box
   `ASSERT_SYNC(a_hold_valid, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid)
   `ASSERT_SYNC(a_hold_data, clock, reset, rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
   `ASSERT_SYNC(a_empty_box, clock, reset, rsp_tvalid |-> box_ok)
endmodule

bind ssd_detection_box_decoder ssdbd_checker u_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
`default_nettype wire

// ===== tb/ssd_detection_box_decoder_tb.sv =====
// Self-checking testbench for the SSD detection box decoder: directed table, then random lists.
// Depends on ssdbd_pkg and ssd_detection_box_decoder, and through it on the stage modules.
`default_nettype none
module ssd_detection_box_decoder_tb;
   import ssdbd_pkg::*;

   // Run control. The block holds four stages; the SETTLE_CYCLES quiet period covers
   // anything still in flight after the last response.
   localparam int SETTLE_CYCLES = 8;
   localparam int LONG_HOLD     = 40;
   localparam int PHASE_COUNT   = 8;
   localparam int PHASE_ITEMS   = 166;
   localparam int TIMEOUT_TIME  = 2_000_000;

   localparam box_type ZERO_BOX = '0;
   localparam box_type UNIT_BOX = '{box_h: 13'd1, box_w: 13'd1, box_y: 13'd0, box_x: 13'd0};

   typedef struct {
      logic                       set_start;
      logic                       list_end;
      logic [SCORE_BITS-1:0]      score;
      logic signed [REL_BITS-1:0] left;
      logic signed [REL_BITS-1:0] top;
      logic signed [REL_BITS-1:0] right;
      logic signed [REL_BITS-1:0] bottom;
   } proposal_type;

   typedef enum {OUT_STOPPED, OUT_END, OUT_LOW, OUT_BOX} outcome_type;
   typedef enum {ROW_ITEM, ROW_CFG} row_kind_type;
   // CHK_MODEL: expectation from the predictor; CHK_NONE / CHK_BOX: typed in the table
   typedef enum {CHK_MODEL, CHK_NONE, CHK_BOX} check_type;

   typedef struct {
      row_kind_type             kind;
      proposal_type             prop;
      check_type                check;
      box_type                  box;
      logic [CSR_ADDR_BITS-1:0] reg_index;
      logic [CSR_DATA_BITS-1:0] reg_value;
   } stim_row_type;

   // DUT connections; every input starts at a known value
   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_tvalid = 1'b0;
   logic                     req_tready;
   logic [REQ_DATA_BITS-1:0] req_tdata = '0;
   logic                     req_tlast = 1'b0;
   logic                     req_tuser = 1'b0;
   logic                     rsp_tvalid;
   logic                     rsp_tready = 1'b1;
   logic [RSP_DATA_BITS-1:0] rsp_tdata;
   logic                     csr_we = 1'b0;
   logic [CSR_ADDR_BITS-1:0] csr_addr = '0;
   logic [CSR_DATA_BITS-1:0] csr_wdata = '0;

   // Predictor state (shadow registers, list-stop flag, expected boxes) and the directed table
   cfg_type      shadow_cfg;
   logic         list_stopped;
   box_type      pending_boxes[$];
   stim_row_type directed_rows[$];

   // Idling knobs and the long receiver hold-off handshake
   int unsigned send_gap_pct = 0;
   int unsigned stall_pct    = 0;
   int          hold_asked   = 0;
   int          hold_taken   = 0;
   int          hold_left    = 0;

   // Statistics and failures
   int mismatches   = 0;
   int n_accepted   = 0;
   int n_boxes      = 0;
   int n_empty      = 0;
   int n_low        = 0;
   int n_ends       = 0;
   int n_dropped    = 0;
   int n_reg_writes = 0;

   ssd_detection_box_decoder u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Scale a relative corner to pixels; SystemVerilog signed division
   // truncates toward zero, as the block does.
   function automatic longint scale_corner(logic signed [REL_BITS-1:0] rel,
                                           logic [COORD_BITS-1:0] span);
      longint prod;
      longint unit;
      prod = longint'(rel) * longint'(span);
      unit = longint'(1) << FRAC_BITS;
      return prod / unit;
   endfunction

   // Work out what one accepted proposal yields and advance the list-stop flag
   task automatic predict_proposal(input proposal_type p, output outcome_type outcome,
                                   output box_type box);
      longint left, top, right, bottom;
      longint x1, y1, x2, y2;
      longint fx, fy;
      box = '0;
      if (p.set_start)
         list_stopped = 1'b0;
      if (list_stopped) begin
         outcome = OUT_STOPPED;
      end else if (p.list_end) begin
         list_stopped = 1'b1;
         outcome = OUT_END;
      end else if (p.score < shadow_cfg.score_threshold) begin
         outcome = OUT_LOW;
      end else begin
         outcome = OUT_BOX;
         left   = scale_corner(p.left,   shadow_cfg.roi_span_x) + longint'(shadow_cfg.roi_left);
         top    = scale_corner(p.top,    shadow_cfg.roi_span_y) + longint'(shadow_cfg.roi_top);
         right  = scale_corner(p.right,  shadow_cfg.roi_span_x) + longint'(shadow_cfg.roi_left);
         bottom = scale_corner(p.bottom, shadow_cfg.roi_span_y) + longint'(shadow_cfg.roi_top);
         // intersect with the frame rectangle
         fx = longint'(shadow_cfg.frame_span_x);
         fy = longint'(shadow_cfg.frame_span_y);
         x1 = (left > 0) ? left : 0;
         y1 = (top > 0) ? top : 0;
         x2 = (right < fx) ? right : fx;
         y2 = (bottom < fy) ? bottom : fy;
         if (!(right <= left || bottom <= top || x2 <= x1 || y2 <= y1)) begin
            box.box_x = x1[COORD_BITS-1:0];
            box.box_y = y1[COORD_BITS-1:0];
            box.box_w = COORD_BITS'(x2 - x1);
            box.box_h = COORD_BITS'(y2 - y1);
         end
      end
   endtask

   function automatic void check_field(string name, logic [COORD_BITS-1:0] want,
                                       logic [COORD_BITS-1:0] seen);
      if (want !== seen) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, seen);
         mismatches++;
      end
   endfunction

   // Compare every response transaction with the oldest expected box
   always @(posedge clock) begin : rsp_check
      box_type want;
      box_type seen;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = rsp_tdata[4*COORD_BITS-1:0];
         if (pending_boxes.size() == 0) begin
            $error("unexpected response: box_x %0d box_y %0d box_w %0d box_h %0d",
                   seen.box_x, seen.box_y, seen.box_w, seen.box_h);
            mismatches++;
         end else begin
            want = pending_boxes.pop_front();
            check_field("box_x", want.box_x, seen.box_x);
            check_field("box_y", want.box_y, seen.box_y);
            check_field("box_w", want.box_w, seen.box_w);
            check_field("box_h", want.box_h, seen.box_h);
         end
      end
   end

   // Receiver: random stalls, plus a long hold-off whenever the stimulus asks
   // for one (counted here, so the sender keeps offering meanwhile)
   always @(negedge clock) begin
      if (hold_taken != hold_asked) begin
         hold_taken <= hold_asked;
         hold_left  <= LONG_HOLD;
         rsp_tready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left  <= hold_left - 1;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= stall_pct);
      end
   end

   // Write one register at the next rising edge and mirror it in the shadow copy
   task automatic write_reg(input logic [CSR_ADDR_BITS-1:0] index,
                            input logic [CSR_DATA_BITS-1:0] value);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_addr  <= index;
      csr_wdata <= value;
      case (index)
         REG_ROI_LEFT:     shadow_cfg.roi_left        = value[COORD_BITS-1:0];
         REG_ROI_TOP:      shadow_cfg.roi_top         = value[COORD_BITS-1:0];
         REG_ROI_SPAN_X:   shadow_cfg.roi_span_x      = value[COORD_BITS-1:0];
         REG_ROI_SPAN_Y:   shadow_cfg.roi_span_y      = value[COORD_BITS-1:0];
         REG_FRAME_SPAN_X: shadow_cfg.frame_span_x    = value[COORD_BITS-1:0];
         REG_FRAME_SPAN_Y: shadow_cfg.frame_span_y    = value[COORD_BITS-1:0];
         REG_SCORE_THR:    shadow_cfg.score_threshold = value;
         default: ;
      endcase
      n_reg_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic release_request();
      @(negedge clock);
      req_tvalid <= 1'b0;
   endtask

   // Hold until every expected box has come, then let the pipeline go quiet
   task automatic wait_idle();
      while (pending_boxes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Offer one proposal, wait for its transaction, then queue what it should yield.
   // live is 0 when the block is expected to ignore it (stopped list).
   task automatic send_item(input proposal_type p, input check_type chk,
                            input box_type typed_box, output bit live);
      outcome_type outcome;
      box_type     box;
      if (send_gap_pct != 0) begin
         while ($urandom_range(99) < send_gap_pct) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
         end
      end
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= {7'b0, p.bottom, p.right, p.top, p.left, p.score};
      req_tlast  <= p.list_end;
      req_tuser  <= p.set_start;
      @(posedge clock);
      while (!req_tready)
         @(posedge clock);
      predict_proposal(p, outcome, box);
      n_accepted++;
      case (outcome)
         OUT_STOPPED: n_dropped++;
         OUT_END:     n_ends++;
         OUT_LOW:     n_low++;
         default: begin
            if (box == ZERO_BOX)
               n_empty++;
            else
               n_boxes++;
         end
      endcase
      case (chk)
         CHK_MODEL: if (outcome == OUT_BOX) pending_boxes.insert(pending_boxes.size(), box);
         CHK_BOX:   pending_boxes.insert(pending_boxes.size(), typed_box);
         default: ;
      endcase
      live = (outcome != OUT_STOPPED);
   endtask

   function automatic void add_item(input logic ss, input logic le, input int score,
                                    input int l, input int t, input int r, input int b,
                                    input check_type chk, input box_type bx);
      stim_row_type row;
      row.kind           = ROW_ITEM;
      row.prop.set_start = ss;
      row.prop.list_end  = le;
      row.prop.score     = SCORE_BITS'(score);
      row.prop.left      = REL_BITS'(l);
      row.prop.top       = REL_BITS'(t);
      row.prop.right     = REL_BITS'(r);
      row.prop.bottom    = REL_BITS'(b);
      row.check          = chk;
      row.box            = bx;
      row.reg_index      = '0;
      row.reg_value      = '0;
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   function automatic void add_cfg(input logic [CSR_ADDR_BITS-1:0] index, input int value);
      stim_row_type row;
      row.kind      = ROW_CFG;
      row.prop      = '{default: '0};
      row.check     = CHK_NONE;
      row.box       = ZERO_BOX;
      row.reg_index = index;
      row.reg_value = CSR_DATA_BITS'(value);
      directed_rows.insert(directed_rows.size(), row);
   endfunction

   // Random proposal with clear flags: mostly ordered corners, some raw noise
   function automatic proposal_type random_proposal();
      proposal_type p;
      int lo_x, lo_y, hi_x, hi_y;
      p.set_start = 1'b0;
      p.list_end  = 1'b0;
      if ($urandom_range(7) == 0)
         p.score = SCORE_BITS'($urandom_range(131071));
      else
         p.score = SCORE_BITS'($urandom_range(65536));
      if ($urandom_range(3) == 0) begin
         p.left   = REL_BITS'($urandom);
         p.top    = REL_BITS'($urandom);
         p.right  = REL_BITS'($urandom);
         p.bottom = REL_BITS'($urandom);
      end else begin
         lo_x = int'($urandom_range(40959)) - 8192;
         lo_y = int'($urandom_range(40959)) - 8192;
         hi_x = lo_x + int'($urandom_range(1, 16384));
         hi_y = lo_y + int'($urandom_range(1, 16384));
         if (hi_x > 32767) hi_x = 32767;
         if (hi_y > 32767) hi_y = 32767;
         p.left   = REL_BITS'(lo_x);
         p.top    = REL_BITS'(lo_y);
         p.right  = REL_BITS'(hi_x);
         p.bottom = REL_BITS'(hi_y);
      end
      return p;
   endfunction

   initial begin : stimulus
      logic [CSR_DATA_BITS-1:0] settings [REG_ROI_LEFT:REG_SCORE_THR];
      proposal_type p;
      bit           live;
      bit           held;
      bit           drained;
      int           counted;
      int           list_len;
      int           fx, fy;

      // Shadow copy starts at the reset values of the block
      shadow_cfg.roi_left        = '0;
      shadow_cfg.roi_top         = '0;
      shadow_cfg.roi_span_x      = 13'd1;
      shadow_cfg.roi_span_y      = 13'd1;
      shadow_cfg.frame_span_x    = 13'd1;
      shadow_cfg.frame_span_y    = 13'd1;
      shadow_cfg.score_threshold = 17'd32768;
      list_stopped               = 1'b0;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Reset settings: unit spans and frame, so a full-scale corner lands on pixel 1
      add_item(0, 0, 65536,  0, 0, 16384, 16384, CHK_BOX, UNIT_BOX);
      add_item(0, 0, 32768,  0, 0, 32767, 32767, CHK_BOX, UNIT_BOX); // score equals threshold
      add_item(0, 0, 32767,  0, 0, 16384, 16384, CHK_NONE, ZERO_BOX); // just below threshold
      add_item(0, 0, 0,      0, 0, 16384, 16384, CHK_NONE, ZERO_BOX);
      add_item(0, 0, 131071, -32768, -32768, 32767, 32767, CHK_BOX, UNIT_BOX); // score above 1.0
      add_item(0, 0, 65536,  16384, 16384, 0, 0, CHK_BOX, ZERO_BOX); // inverted box
      add_item(0, 1, 65536,  0, 0, 16384, 16384, CHK_NONE, ZERO_BOX); // end marker stops list
      add_item(0, 0, 65536,  0, 0, 16384, 16384, CHK_NONE, ZERO_BOX); // dropped while stopped
      add_item(1, 0, 65536,  0, 0, 16384, 16384, CHK_BOX, UNIT_BOX); // new set reopens
      add_item(1, 1, 65536,  0, 0, 16384, 16384, CHK_NONE, ZERO_BOX); // reopen and stop at once
      add_item(0, 1, 65536,  0, 0, 16384, 16384, CHK_NONE, ZERO_BOX);
      add_item(1, 0, 131071, -1, -1, -1, -1, CHK_BOX, ZERO_BOX); // small negatives truncate to 0
      add_item(0, 0, 65536,  0, 0, 16384, 16384, CHK_BOX, UNIT_BOX);
      // Every register at its maximum, threshold at zero
      add_cfg(REG_ROI_LEFT, 8191);
      add_cfg(REG_ROI_TOP, 8191);
      add_cfg(REG_ROI_SPAN_X, 8191);
      add_cfg(REG_ROI_SPAN_Y, 8191);
      add_cfg(REG_FRAME_SPAN_X, 8191);
      add_cfg(REG_FRAME_SPAN_Y, 8191);
      add_cfg(REG_SCORE_THR, 0);
      add_item(0, 0, 0,      -32768, -32768, 32767, 32767, CHK_MODEL, ZERO_BOX);
      add_item(0, 0, 131071, 0, 0, 0, 0, CHK_MODEL, ZERO_BOX);
      add_item(0, 0, 65536,  32767, -32768, -32768, 32767, CHK_MODEL, ZERO_BOX);
      add_item(0, 0, 1,      -32768, -32768, -16384, -16384, CHK_MODEL, ZERO_BOX);
      // Zero ROI spans collapse every corner; top threshold
      add_cfg(REG_ROI_LEFT, 0);
      add_cfg(REG_ROI_TOP, 0);
      add_cfg(REG_ROI_SPAN_X, 0);
      add_cfg(REG_ROI_SPAN_Y, 0);
      add_cfg(REG_SCORE_THR, 65536);
      add_item(0, 0, 65536,  -32768, -32768, 32767, 32767, CHK_BOX, ZERO_BOX);
      add_item(0, 0, 65535,  -32768, -32768, 32767, 32767, CHK_NONE, ZERO_BOX);
      // Zero frame width makes every box empty
      add_cfg(REG_ROI_SPAN_X, 4000);
      add_cfg(REG_ROI_SPAN_Y, 3000);
      add_cfg(REG_ROI_LEFT, 10);
      add_cfg(REG_ROI_TOP, 20);
      add_cfg(REG_FRAME_SPAN_X, 0);
      add_cfg(REG_SCORE_THR, 1);
      add_item(0, 0, 65536,  4096, 4096, 8192, 8192, CHK_BOX, ZERO_BOX);
      // Ordinary frame: clipped far edge, clipped at the origin, missed, low score, clipped far edge
      add_cfg(REG_FRAME_SPAN_X, 1920);
      add_cfg(REG_FRAME_SPAN_Y, 1080);
      add_item(0, 0, 40000,  4096, 4096, 8192, 8192, CHK_MODEL, ZERO_BOX);
      add_item(0, 0, 40000,  -4096, -4096, 4096, 4096, CHK_MODEL, ZERO_BOX);
      add_item(0, 0, 40000,  16384, 16384, 32767, 32767, CHK_MODEL, ZERO_BOX);
      add_item(0, 0, 0,      4096, 4096, 8192, 8192, CHK_NONE, ZERO_BOX);
      add_item(0, 0, 1,      100, 200, 12000, 9000, CHK_MODEL, ZERO_BOX);

      // Walk the directed table with no idling
      foreach (directed_rows[i]) begin
         if (directed_rows[i].kind == ROW_CFG) begin
            release_request();
            wait_idle();
            write_reg(directed_rows[i].reg_index, directed_rows[i].reg_value);
         end else begin
            send_item(directed_rows[i].prop, directed_rows[i].check,
                      directed_rows[i].box, live);
         end
      end

      // Random phases: new settings and a new idling pattern each time
      for (int phase = 0; phase < PHASE_COUNT; phase++) begin
         release_request();
         wait_idle();
         case (phase % 4)
            0: begin send_gap_pct = 0;  stall_pct = 0;  end
            1: begin send_gap_pct = 63; stall_pct = 0;  end
            2: begin send_gap_pct = 0;  stall_pct = 63; end
            default: begin send_gap_pct = 27; stall_pct = 27; end
         endcase
         if (phase == 1) begin
            // top of every coordinate range, threshold at 65536
            settings[REG_ROI_LEFT]     = 8191;
            settings[REG_ROI_TOP]      = 8191;
            settings[REG_ROI_SPAN_X]   = 8191;
            settings[REG_ROI_SPAN_Y]   = 8191;
            settings[REG_FRAME_SPAN_X] = 8191;
            settings[REG_FRAME_SPAN_Y] = 8191;
            settings[REG_SCORE_THR]    = 65536;
         end else if (phase == 2) begin
            // bottom of every range, but spans and frame at 1
            settings[REG_ROI_LEFT]     = 0;
            settings[REG_ROI_TOP]      = 0;
            settings[REG_ROI_SPAN_X]   = 1;
            settings[REG_ROI_SPAN_Y]   = 1;
            settings[REG_FRAME_SPAN_X] = 1;
            settings[REG_FRAME_SPAN_Y] = 1;
            settings[REG_SCORE_THR]    = 0;
         end else begin
            fx = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(1, 8191));
            fy = ($urandom_range(15) == 0) ? 0 : int'($urandom_range(1, 8191));
            settings[REG_FRAME_SPAN_X] = CSR_DATA_BITS'(fx);
            settings[REG_FRAME_SPAN_Y] = CSR_DATA_BITS'(fy);
            settings[REG_ROI_LEFT]     = CSR_DATA_BITS'($urandom_range(fx));
            settings[REG_ROI_TOP]      = CSR_DATA_BITS'($urandom_range(fy));
            settings[REG_ROI_SPAN_X]   = ($urandom_range(15) == 0) ? '0
                                         : CSR_DATA_BITS'($urandom_range(1, 8191));
            settings[REG_ROI_SPAN_Y]   = ($urandom_range(15) == 0) ? '0
                                         : CSR_DATA_BITS'($urandom_range(1, 8191));
            settings[REG_SCORE_THR]    = ($urandom_range(7) == 0)
                                         ? CSR_DATA_BITS'($urandom_range(65537, 131071))
                                         : CSR_DATA_BITS'($urandom_range(65536));
         end
         for (int r = REG_ROI_LEFT; r <= REG_SCORE_THR; r++)
            write_reg(CSR_ADDR_BITS'(r), settings[r]);

         counted = 0;
         held    = 1'b0;
         drained = 1'b0;
         while (counted < PHASE_ITEMS) begin
            if ($urandom_range(9) == 0) begin
               // noise: any flag combination, often landing on a stopped list
               p = random_proposal();
               p.set_start = 1'($urandom_range(1));
               p.list_end  = ($urandom_range(2) == 0);
               send_item(p, CHK_MODEL, ZERO_BOX, live);
               if (live) counted++;
            end else begin
               // well-formed list; now and then the end marker is left off
               list_len = $urandom_range(1, 12);
               for (int k = 0; k < list_len; k++) begin
                  p = random_proposal();
                  p.set_start = (k == 0);
                  p.list_end  = (k == list_len - 1) && ($urandom_range(7) != 0);
                  send_item(p, CHK_MODEL, ZERO_BOX, live);
                  if (live) counted++;
               end
            end
            // Hold the receiver off while the sender keeps going, to back up the pipeline
            if (!held && (phase % 4) == 0 && counted >= 60) begin
               hold_asked++;
               held = 1'b1;
            end
            // Pause the sender until everything outstanding has drained
            if (!drained && phase == 1 && counted >= 80) begin
               release_request();
               while (pending_boxes.size() != 0)
                  @(posedge clock);
               drained = 1'b1;
            end
         end
      end

      release_request();
      wait_idle();
      $display("covered %0d proposals over %0d register writes: %0d boxes, %0d empty boxes,",
               n_accepted, n_reg_writes, n_boxes, n_empty);
      $display("  %0d below threshold, %0d end markers, %0d dropped on a stopped list",
               n_low, n_ends, n_dropped);
      if (mismatches == 0)
         $display("ssd_detection_box_decoder_tb: done, clean");
      else
         $display("ssd_detection_box_decoder_tb: done, errors");
      $finish;
   end

   // Watchdog: a hung handshake ends the run as a failure
   initial begin
      #(TIMEOUT_TIME);
      $display("ssd_detection_box_decoder_tb: done, errors");
      $finish;
   end

endmodule
`default_nettype wire
